// ===== design/fsub_pkg.sv =====
package fsub_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 16;
    localparam int SEEN_BITS   = 17;
    localparam int LEN_BITS    = 5;
    localparam int PIDX_BITS   = $clog2(MAX_PATTERN);
    localparam int CFG_BITS    = 64;
    localparam int CIDX_BITS   = 2;

    localparam logic [CIDX_BITS-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CIDX_BITS-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CIDX_BITS-1:0] CFG_PATTERN_LENGTH = 2'd2;

    localparam logic STATUS_FOUND     = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       has_byte;
        logic       last_item;
    } t_in_item;

    typedef struct packed {
        logic                   status;
        logic [OFFSET_BITS-1:0] match_offset;
    } t_out_item;

    typedef struct packed {
        logic shift;
        logic active;
    } t_cell_ctrl;

endpackage

// ===== design/first_substring_match_top.sv =====
// First substring match.
// Input channel (i_in_valid / o_in_ready / i_in): one item per text byte, or an
// end-only item with has_byte low; last_item marks the end of a text.
// Output channel (o_out_valid / i_out_ready / o_out): at most one item per text,
// found with the start offset of the first match, or not found at the end.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
// index 0 pattern bytes 0..7, 1 bytes 8..15, 2 pattern length; always ready.
// Throughput: one item per cycle while the skid entry is free. A row of 16
// byte cells shifts the text and compares every window position with the
// pattern in the accepting cycle; each result is registered before it is visible.
// Stall: results go to an output register backed by one skid entry; input is
// taken while the skid entry is free, so a stalled receiver holds at most two
// results before o_in_ready drops.
// Reset: pattern registers, byte count, found flag and both result slots clear.
// Bytes after a match are ignored until the text ends; the offset saturates
// at its maximum.
module first_substring_match_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  fsub_pkg::t_in_item                   i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output fsub_pkg::t_out_item                  o_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fsub_pkg::CIDX_BITS-1:0]       i_cfg_index,
    input  logic [fsub_pkg::CFG_BITS-1:0]        i_cfg_data
);

    localparam int NP = fsub_pkg::MAX_PATTERN;
    localparam int SB = fsub_pkg::SEEN_BITS;
    localparam int LB = fsub_pkg::LEN_BITS;
    localparam int OB = fsub_pkg::OFFSET_BITS;
    localparam int PB = fsub_pkg::PIDX_BITS;

    logic [fsub_pkg::CFG_BITS-1:0] r_pat_low;
    logic [fsub_pkg::CFG_BITS-1:0] r_pat_high;
    logic [LB-1:0]                 r_pat_len;
    logic [SB-1:0]                 r_seen;
    logic                          r_found;
    logic [SB-1:0]                 n_seen;
    logic                          n_found;

    logic [2*fsub_pkg::CFG_BITS-1:0] pat_all;
    logic                  acc;
    logic                  shift;
    logic                  len_ok;
    logic [SB-1:0]         seen_inc;
    logic [SB-1:0]         diff;
    logic [NP-1:0]         hits;
    logic [7:0]            cell_in  [NP];
    logic [7:0]            cell_out [NP];
    logic                  match;
    logic                  push;
    logic                  can_push;
    fsub_pkg::t_out_item   push_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fsub_pkg::CFG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                fsub_pkg::CFG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                fsub_pkg::CFG_PATTERN_LENGTH: r_pat_len  <= i_cfg_data[LB-1:0];
                default: ;
            endcase
        end
    end

    assign pat_all    = {r_pat_high, r_pat_low};
    assign o_in_ready = can_push;
    assign acc        = i_in_valid && can_push;
    assign shift      = acc && i_in.has_byte && !r_found;
    assign len_ok     = (r_pat_len != '0) && ({1'b0, r_pat_len} <= (LB+1)'(NP));
    assign seen_inc   = (r_seen == {SB{1'b1}}) ? r_seen : r_seen + SB'(1);

    genvar gi;
    generate
        for (gi = 0; gi < NP; gi++) begin : g_cell
            fsub_pkg::t_cell_ctrl ctrl;
            logic [LB-1:0]        pidx_w;
            logic [7:0]           pbyte;

            assign pidx_w      = r_pat_len - LB'(1) - LB'(gi);
            assign pbyte       = pat_all[8*pidx_w[PB-1:0] +: 8];
            assign ctrl.shift  = shift;
            assign ctrl.active = (LB'(gi) < r_pat_len);

            if (gi == 0) begin : g_head
                assign cell_in[gi] = i_in.text_byte;
            end else begin : g_link
                assign cell_in[gi] = cell_out[gi-1];
            end

            fsub_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (ctrl),
                .i_byte     (cell_in[gi]),
                .i_pat_byte (pbyte),
                .o_byte     (cell_out[gi]),
                .o_hit      (hits[gi])
            );
        end
    endgenerate

    assign match = shift && len_ok && (seen_inc >= SB'(r_pat_len)) && (&hits);
    assign diff  = seen_inc - SB'(r_pat_len);

    always_comb begin
        push_item = '0;
        push      = 1'b0;
        if (match) begin
            push                   = 1'b1;
            push_item.status       = fsub_pkg::STATUS_FOUND;
            push_item.match_offset = (diff > SB'({OB{1'b1}})) ? {OB{1'b1}} : diff[OB-1:0];
        end else if (acc && i_in.last_item && !r_found) begin
            push             = 1'b1;
            push_item.status = fsub_pkg::STATUS_NOT_FOUND;
        end
    end

    always_comb begin
        n_seen  = r_seen;
        n_found = r_found;
        if (acc && i_in.last_item) begin
            n_seen  = '0;
            n_found = 1'b0;
        end else begin
            if (shift) begin
                n_seen = seen_inc;
            end
            if (match) begin
                n_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_found <= 1'b0;
        end else begin
            r_seen  <= n_seen;
            r_found <= n_found;
        end
    end

    fsub_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_can_push  (can_push),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_item      (o_out)
    );

endmodule

// ===== design/fsub_cell.sv =====
module fsub_cell (
    input  logic                 i_clk,
    input  fsub_pkg::t_cell_ctrl i_ctrl,
    input  logic [7:0]           i_byte,
    input  logic [7:0]           i_pat_byte,
    output logic [7:0]           o_byte,
    output logic                 o_hit
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= i_byte;
        end
    end

    // compare against the byte this cell holds after the shift
    assign o_hit  = !i_ctrl.active || (i_byte == i_pat_byte);
    assign o_byte = r_byte;

endmodule

// ===== design/fsub_obuf.sv =====
module fsub_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fsub_pkg::t_out_item i_push_item,
    output logic                o_can_push,
    output logic                o_valid,
    input  logic                i_ready,
    output fsub_pkg::t_out_item o_item
);

    logic                r_out_valid;
    logic                r_skid_valid;
    fsub_pkg::t_out_item r_out;
    fsub_pkg::t_out_item r_skid;
    logic                take;

    assign take = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out       <= i_push_item;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_push_item;
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_item     = r_out;

endmodule

// ===== design/fsub_checker.sv =====
module fsub_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input fsub_pkg::t_in_item             i_in,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input fsub_pkg::t_out_item            o_out,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [fsub_pkg::CIDX_BITS-1:0] i_cfg_index,
    input logic [fsub_pkg::CFG_BITS-1:0]  i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == fsub_pkg::STATUS_NOT_FOUND)
        |-> (o_out.match_offset == '0))
        else $error("not found result with nonzero offset");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("result or stall visible after reset");

    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

endmodule

bind first_substring_match_top fsub_checker u_fsub_checker (.*);

// ===== tb/sv/first_substring_match_top_tb.sv =====
`timescale 1ns / 1ps

module first_substring_match_top_tb;
    import fsub_pkg::*;

    localparam logic [CIDX_BITS-1:0]   CFG_UNUSED   = 2'd3;
    localparam logic [SEEN_BITS-1:0]   SEEN_MAX     = '1;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX   = '1;
    localparam int                     DRAIN_CYCLES = 4;
    localparam int                     HOLD_CYCLES  = 200;
    localparam int                     RAND_PHASES  = 16;
    localparam int                     PHASE_ITEMS  = 82;
    localparam int                     PRESS_PHASE  = 3;

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_e;
    typedef enum logic [1:0] { CHK_MODEL, CHK_NONE, CHK_GIVEN } chk_e;

    typedef struct {
        row_kind_e            kind;
        logic [CIDX_BITS-1:0] idx;
        logic [CFG_BITS-1:0]  data;
        t_in_item             it;
        chk_e                 chk;
        t_out_item            want;
    } dir_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CIDX_BITS-1:0] i_cfg_index;
    logic [CFG_BITS-1:0]  i_cfg_data;

    // search state mirror; pattern[k] is pattern byte k, window[0] is the newest byte
    logic [MAX_PATTERN-1:0][7:0] pattern;
    logic [LEN_BITS-1:0]         pattern_len;
    logic [MAX_PATTERN-1:0][7:0] window;
    logic [SEEN_BITS-1:0]        seen;
    logic                        found;

    t_out_item pending_results[$];
    int        mismatches = 0;
    bit        calm       = 1'b0;
    bit        gaps_on    = 1'b1;
    bit        hold_req   = 1'b0;

    first_substring_match_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(10_000_000);
        $display("first_substring_match_top_tb: FAIL");
        $finish;
    end

    function automatic void clear_text();
        window = '0;
        seen   = '0;
        found  = 1'b0;
    endfunction

    function automatic logic window_hit();
        if (pattern_len == 0 || pattern_len > MAX_PATTERN || seen < pattern_len) begin
            return 1'b0;
        end
        for (int k = 0; k < pattern_len; k++) begin
            if (window[pattern_len - 1 - k] != pattern[k]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic search_step(input t_in_item it, output t_out_item res);
        logic [SEEN_BITS-1:0] start;
        logic                 got;
        got = 1'b0;
        res = '0;
        if (it.has_byte && !found) begin
            window = {window[MAX_PATTERN-2:0], it.text_byte};
            if (seen != SEEN_MAX) begin
                seen++;
            end
            if (window_hit()) begin
                start            = seen - pattern_len;
                found            = 1'b1;
                res.status       = STATUS_FOUND;
                res.match_offset = (start > OFFSET_MAX) ? OFFSET_MAX
                                                        : start[OFFSET_BITS-1:0];
                got              = 1'b1;
            end
        end
        if (it.last_item) begin
            if (!found) begin
                res.status       = STATUS_NOT_FOUND;
                res.match_offset = '0;
                got              = 1'b1;
            end
            clear_text();
        end
        return got;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CIDX_BITS-1:0] idx,
                                         input logic [CFG_BITS-1:0] data);
        dir_row_t r;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        r.it   = '0;
        r.chk  = CHK_NONE;
        r.want = '0;
        return r;
    endfunction

    function automatic dir_row_t item_row(input logic [7:0] b, input logic has,
                                          input logic last, input chk_e chk);
        dir_row_t r;
        r.kind         = ROW_ITEM;
        r.idx          = '0;
        r.data         = '0;
        r.it.text_byte = b;
        r.it.has_byte  = has;
        r.it.last_item = last;
        r.chk          = chk;
        r.want         = '0;
        return r;
    endfunction

    function automatic dir_row_t given_row(input logic [7:0] b, input logic has,
                                           input logic last, input logic st,
                                           input logic [OFFSET_BITS-1:0] off);
        dir_row_t r;
        r                   = item_row(b, has, last, CHK_GIVEN);
        r.want.status       = st;
        r.want.match_offset = off;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 50) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic cfg_write(input logic [CIDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PATTERN_LOW:    pattern[7:0]  = data;
            CFG_PATTERN_HIGH:   pattern[15:8] = data;
            CFG_PATTERN_LENGTH: pattern_len   = data[LEN_BITS-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input t_in_item it, input chk_e chk, input t_out_item want);
        t_out_item res;
        logic      got;
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        got = search_step(it, res);
        if (chk == CHK_MODEL && got) begin
            pending_results.push_back(res);
        end else if (chk == CHK_GIVEN) begin
            pending_results.push_back(want);
        end
        if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic random_config();
        logic [MAX_PATTERN-1:0][7:0] pb;
        logic [LEN_BITS-1:0]         len;
        int                          mode;
        mode = $urandom_range(0, 7);
        for (int k = 0; k < MAX_PATTERN; k++) begin
            case (mode)
                0: pb[k] = 8'h00;
                1: pb[k] = 8'hFF;
                2, 3: begin
                    // few distinct bytes give overlapping prefixes
                    case ($urandom_range(0, 2))
                        0: pb[k] = 8'h00;
                        1: pb[k] = 8'hFF;
                        default: pb[k] = 8'h5A;
                    endcase
                end
                default: pb[k] = 8'($urandom);
            endcase
        end
        case ($urandom_range(0, 19))
            0: len = '0;
            1: len = LEN_BITS'($urandom_range(MAX_PATTERN + 1, 31));
            2, 3: len = LEN_BITS'(MAX_PATTERN);
            default: len = LEN_BITS'($urandom_range(1, MAX_PATTERN - 1));
        endcase
        cfg_write(CFG_PATTERN_LOW, pb[7:0]);
        cfg_write(CFG_PATTERN_HIGH, pb[15:8]);
        cfg_write(CFG_PATTERN_LENGTH, CFG_BITS'(len));
    endtask

    task automatic send_text(output int n_items);
        logic [7:0] text_q[$];
        t_in_item   it;
        t_out_item  none;
        int         n;
        int         len;
        int         pos;
        logic       end_on_byte;
        none    = '0;
        n_items = 0;
        len     = (pattern_len >= 1 && pattern_len <= MAX_PATTERN) ? pattern_len : 0;
        n       = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(1, 40);
        for (int i = 0; i < n; i++) begin
            if (len != 0 && $urandom_range(0, 1) == 1) begin
                text_q.push_back(pattern[$urandom_range(0, len - 1)]);
            end else begin
                text_q.push_back(8'($urandom));
            end
        end
        if (len != 0 && $urandom_range(0, 3) != 0) begin
            pos = $urandom_range(0, n);
            for (int i = 0; i < len; i++) begin
                if (pos + i < text_q.size()) begin
                    text_q[pos + i] = pattern[i];
                end else begin
                    text_q.push_back(pattern[i]);
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                // near miss
                text_q[pos + $urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
            end
        end
        end_on_byte = $urandom_range(0, 1);
        for (int i = 0; i < text_q.size(); i++) begin
            if ($urandom_range(0, 9) == 0) begin
                it.text_byte = 8'($urandom);
                it.has_byte  = 1'b0;
                it.last_item = 1'b0;
                send_item(it, CHK_MODEL, none);
            end
            it.text_byte = text_q[i];
            it.has_byte  = 1'b1;
            it.last_item = end_on_byte && (i == text_q.size() - 1);
            send_item(it, CHK_MODEL, none);
            n_items++;
        end
        if (!end_on_byte || text_q.size() == 0) begin
            it.text_byte = 8'($urandom);
            it.has_byte  = 1'b0;
            it.last_item = 1'b1;
            send_item(it, CHK_MODEL, none);
            n_items++;
        end
    endtask

    // output handshake and checks
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected item: status %0b offset %0d",
                                          o_out.status, o_out.match_offset));
            end else begin
                want = pending_results.pop_front();
                if (o_out.status !== want.status) begin
                    report_mismatch($sformatf("status %0b, expected %0b",
                                              o_out.status, want.status));
                end
                if (o_out.match_offset !== want.match_offset) begin
                    report_mismatch($sformatf("match_offset %0d, expected %0d",
                                              o_out.match_offset, want.match_offset));
                end
            end
        end
    end

    // receiver backpressure
    initial begin
        i_out_ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (calm) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) != 0) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial begin
        dir_row_t  rows[$];
        int        phase_items;
        int        n;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        pattern     = '0;
        pattern_len = '0;
        clear_text();

        rows = '{
            // empty pattern after reset
            given_row(8'h00, 1'b1, 1'b1, STATUS_NOT_FOUND, 16'd0),
            cfg_row(CFG_PATTERN_LOW, 64'h0000_0000_0043_4241),
            cfg_row(CFG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF),
            cfg_row(CFG_PATTERN_LENGTH, 64'd3),
            item_row(8'h41, 1'b1, 1'b0, CHK_NONE),
            item_row(8'h42, 1'b1, 1'b0, CHK_NONE),
            given_row(8'h43, 1'b1, 1'b0, STATUS_FOUND, 16'd0),
            // ignored after a match
            item_row(8'hFF, 1'b1, 1'b0, CHK_NONE),
            item_row(8'h00, 1'b0, 1'b1, CHK_NONE),
            // text shorter than pattern
            item_row(8'h41, 1'b1, 1'b0, CHK_NONE),
            given_row(8'h42, 1'b1, 1'b1, STATUS_NOT_FOUND, 16'd0),
            // match on the final item
            item_row(8'h00, 1'b1, 1'b0, CHK_NONE),
            item_row(8'h41, 1'b1, 1'b0, CHK_NONE),
            item_row(8'h42, 1'b1, 1'b0, CHK_NONE),
            given_row(8'h43, 1'b1, 1'b1, STATUS_FOUND, 16'd1),
            // items without a byte
            item_row(8'hFF, 1'b0, 1'b0, CHK_NONE),
            given_row(8'h41, 1'b0, 1'b1, STATUS_NOT_FOUND, 16'd0),
            cfg_row(CFG_UNUSED, '1),
            item_row(8'h41, 1'b1, 1'b0, CHK_MODEL),
            item_row(8'h42, 1'b1, 1'b0, CHK_MODEL),
            item_row(8'h43, 1'b1, 1'b1, CHK_MODEL),
            // overlong lengths
            cfg_row(CFG_PATTERN_LENGTH, 64'd31),
            given_row(8'h41, 1'b1, 1'b1, STATUS_NOT_FOUND, 16'd0),
            cfg_row(CFG_PATTERN_LENGTH, 64'd17),
            given_row(8'h43, 1'b1, 1'b1, STATUS_NOT_FOUND, 16'd0),
            // zero byte pattern
            cfg_row(CFG_PATTERN_LOW, 64'd0),
            cfg_row(CFG_PATTERN_LENGTH, 64'd1),
            item_row(8'hFF, 1'b1, 1'b0, CHK_NONE),
            given_row(8'h00, 1'b1, 1'b0, STATUS_FOUND, 16'd1),
            item_row(8'h00, 1'b1, 1'b1, CHK_NONE)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                cfg_write(rows[r].idx, rows[r].data);
            end else begin
                send_item(rows[r].it, rows[r].chk, rows[r].want);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            random_config();
            calm    = (p >= RAND_PHASES - 2);
            gaps_on = (p != PRESS_PHASE) && (p % 4 != 1);
            if (p == PRESS_PHASE) begin
                hold_req = 1'b1;
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                send_text(n);
                phase_items += n;
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("first_substring_match_top_tb: PASS");
        end else begin
            $display("first_substring_match_top_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== first_substring_match_top.f =====
design/fsub_pkg.sv
design/fsub_cell.sv
design/fsub_obuf.sv
design/first_substring_match_top.sv
design/fsub_checker.sv
tb/sv/first_substring_match_top_tb.sv
